// File: rtl/gmor_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the grid MAD outlier removal block.
// Used by the controller, the datapath and the top level.
package gmor_pkg;

    // Defaults for the top level parameters.
    localparam int MAX_ROWS_DEF   = 32;
    localparam int MAX_COLS_DEF   = 32;
    localparam int COORD_BITS_DEF = 24;

    // Fixed field widths.
    localparam int FIELD_W    = 24;
    localparam int ROWCOL_W   = 5;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIM_W      = 6;
    localparam int SIGMA_W    = 16;
    localparam int D_W        = 52;
    localparam int CNT_W      = 11;
    localparam int GRID_IDX_W = 10;

    localparam logic [CNT_W-1:0]   REM_MAX    = 11'd2047;
    localparam logic [DIM_W-1:0]   ROWS_RST   = 6'd32;
    localparam logic [DIM_W-1:0]   COLS_RST   = 6'd32;
    localparam logic [SIGMA_W-1:0] SIGMA_RST  = 16'd768;

    // Threshold scaling: floor(65536 / 0.6745) and the digit-serial product.
    localparam int KC_W     = 33;
    localparam logic [KC_W-1:0] MAD_INV_Q16 = 33'd97162;
    localparam int DIGIT_W  = 13;
    localparam int DIGITS   = 4;
    localparam int PROD_W   = DIGIT_W + KC_W;
    localparam int ACC_W    = D_W + KC_W;
    localparam int SCALE_SH = 24;
    localparam int TERM_W   = ACC_W - SCALE_SH;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_COMPUTE = 2'd1,
        CMD_READ    = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic walk_rst;
        logic walk_inc;
        logic ld_wr;
        logic rd_issue;
        logic rd_cap;
        logic pt_issue;
        logic ctr_cap;
        logic nb_inc;
        logic nb_issue;
        logic nb_cap;
        logic mul_step;
        logic d_store;
        logic d_min;
        logic mark_wr;
        logic n_rst;
        logic zero_stats;
        logic sel_init;
        logic sel_issue;
        logic sel_bit;
        logic sel_mad;
        logic thr_init;
        logic thr_mul;
        logic thr_acc;
        logic thr_fin;
        logic push_rd;
        logic push_cp;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_last;
        logic in_region;
        logic pt_valid;
        logic nb_last;
        logic nb_in_range;
        logic mul_last;
        logic n_zero;
        logic sel_last;
        logic pipe_empty;
        logic bit_last;
        logic thr_last;
        logic out_free;
    } t_dp_status;

    // Row and column offsets of the eight neighbors, two's complement.
    function automatic logic [GRID_IDX_W-1:0] nb_dr(input logic [2:0] k);
        logic [GRID_IDX_W-1:0] v;
        case (k)
            3'd0, 3'd1, 3'd2: v = '1;
            3'd3, 3'd4:       v = '0;
            default:          v = GRID_IDX_W'(1);
        endcase
        return v;
    endfunction

    function automatic logic [GRID_IDX_W-1:0] nb_dc(input logic [2:0] k);
        logic [GRID_IDX_W-1:0] v;
        case (k)
            3'd0, 3'd3, 3'd5: v = '1;
            3'd1, 3'd6:       v = '0;
            default:          v = GRID_IDX_W'(1);
        endcase
        return v;
    endfunction

endpackage

// File: rtl/grid_mad_outlier_removal_top.sv
`timescale 1ns / 1ps
// Top level of the grid MAD outlier removal block: controller, datapath and ports.
// Depends on gmor_pkg, gmor_ctrl, gmor_dp and gmor_ram.

// After reset the block walks every cell, clearing its point and removed-mark
// memories, and holds the request stall high; configuration writes are taken at
// any time. A load is written from the idle state; a read issues the point memory
// read, captures its registered data and then waits for a free output register. A
// compute walks every grid cell twice; each cell issues and captures its point (and
// writes its mark in the marking walk), and each valid neighbor in range is read
// from memory, squared per axis by one shared squarer and accumulated. Between the
// walks the median and the MAD are found by bit-serial selection over the stored
// distances, 52 passes each, and the threshold by a four-step digit multiply. A
// result waiting in the output register does not block loads.
module grid_mad_outlier_removal_top import gmor_pkg::*; #(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_stall,
    input  logic [CMD_W-1:0]          i_cmd,
    input  logic [ROWCOL_W-1:0]       i_row,
    input  logic [ROWCOL_W-1:0]       i_col,
    input  logic signed [FIELD_W-1:0] i_x,
    input  logic signed [FIELD_W-1:0] i_y,
    input  logic signed [FIELD_W-1:0] i_z,
    input  logic                      i_valid_req,
    output logic                      o_res_valid,
    input  logic                      i_res_stall,
    output logic signed [FIELD_W-1:0] o_out_x,
    output logic signed [FIELD_W-1:0] o_out_y,
    output logic signed [FIELD_W-1:0] o_out_z,
    output logic                      o_out_valid,
    output logic [CNT_W-1:0]          o_removed_total,
    output logic [D_W-1:0]            o_median_sq,
    output logic [D_W-1:0]            o_mad_sq,
    output logic [D_W-1:0]            o_threshold_sq,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);
    t_dp_cmd    ctl;
    t_dp_status st;

    assign o_cfg_ready = 1'b1;

    gmor_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_cmd       (i_cmd),
        .o_req_stall (o_req_stall),
        .i_st        (st),
        .o_ctl       (ctl)
    );

    gmor_dp #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_st            (st),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_x             (i_x),
        .i_y             (i_y),
        .i_z             (i_z),
        .i_valid_req     (i_valid_req),
        .i_res_stall     (i_res_stall),
        .o_res_valid     (o_res_valid),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_z         (o_out_z),
        .o_out_valid     (o_out_valid),
        .o_removed_total (o_removed_total),
        .o_median_sq     (o_median_sq),
        .o_mad_sq        (o_mad_sq),
        .o_threshold_sq  (o_threshold_sq)
    );
endmodule

// File: rtl/gmor_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependency.
module gmor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/gmor_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the grid MAD outlier removal block.
// Depends on gmor_pkg for the command and status structs.
module gmor_ctrl import gmor_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic [CMD_W-1:0]  i_cmd,
    output logic              o_req_stall,
    input  t_dp_status        i_st,
    output t_dp_cmd           o_ctl
);
    typedef enum logic [17:0] {
        S_CLEAR     = 18'h00001,
        S_IDLE      = 18'h00002,
        S_RD        = 18'h00004,
        S_PUSH_RD   = 18'h00008,
        S_P_ISSUE   = 18'h00010,
        S_P_CAP     = 18'h00020,
        S_N_ISSUE   = 18'h00040,
        S_N_CAP     = 18'h00080,
        S_MUL       = 18'h00100,
        S_USE       = 18'h00200,
        S_MARK      = 18'h00400,
        S_SEL_INIT  = 18'h00800,
        S_SEL_RUN   = 18'h01000,
        S_SEL_DRAIN = 18'h02000,
        S_SEL_BIT   = 18'h04000,
        S_THR_INIT  = 18'h08000,
        S_THR_MUL   = 18'h10000,
        S_THR_ACC   = 18'h20000
    } t_state;

    t_state r_state, n_state;
    logic   r_ph2, n_ph2;
    logic   r_madm, n_madm;
    logic   r_fin, n_fin;
    logic   r_pushcp, n_pushcp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ph2    <= 1'b0;
            r_madm   <= 1'b0;
            r_fin    <= 1'b0;
            r_pushcp <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ph2    <= n_ph2;
            r_madm   <= n_madm;
            r_fin    <= n_fin;
            r_pushcp <= n_pushcp;
        end
    end

    always_comb begin
        logic go_nb_next;
        logic go_cell_end;
        go_nb_next  = 1'b0;
        go_cell_end = 1'b0;
        n_state     = r_state;
        n_ph2       = r_ph2;
        n_madm      = r_madm;
        n_fin       = 1'b0;
        n_pushcp    = r_pushcp;
        o_ctl       = '0;
        o_ctl.sel_mad = r_madm;
        o_req_stall = (r_state != S_IDLE) || r_fin || r_pushcp;

        // Threshold finish (single-cycle) and compute result push (held until
        // out_free) are carried by flags so the state set stays compact.
        if (r_fin) begin
            o_ctl.thr_fin  = 1'b1;
            o_ctl.walk_rst = 1'b1;
        end else if (r_pushcp) begin
            if (i_st.out_free) begin
                o_ctl.push_cp = 1'b1;
                n_pushcp      = 1'b0;
            end
        end else begin
            case (r_state)
                S_CLEAR: begin
                    o_ctl.clr_wr   = 1'b1;
                    o_ctl.walk_inc = 1'b1;
                    if (i_st.walk_last) begin
                        n_state = S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        case (i_cmd)
                            CMD_LOAD: o_ctl.ld_wr = 1'b1;
                            CMD_COMPUTE: begin
                                o_ctl.walk_rst = 1'b1;
                                o_ctl.n_rst    = 1'b1;
                                n_ph2          = 1'b0;
                                n_state        = S_P_ISSUE;
                            end
                            CMD_READ: begin
                                o_ctl.rd_issue = 1'b1;
                                n_state        = S_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: begin
                    o_ctl.rd_cap = 1'b1;
                    n_state      = S_PUSH_RD;
                end
                S_PUSH_RD: begin
                    if (i_st.out_free) begin
                        o_ctl.push_rd = 1'b1;
                        n_state       = S_IDLE;
                    end
                end
                S_P_ISSUE: begin
                    o_ctl.pt_issue = 1'b1;
                    n_state        = S_P_CAP;
                end
                S_P_CAP: begin
                    o_ctl.ctr_cap = 1'b1;
                    if (i_st.in_region && i_st.pt_valid) begin
                        n_state = S_N_ISSUE;
                    end else begin
                        go_cell_end = 1'b1;
                    end
                end
                S_N_ISSUE: begin
                    if (i_st.nb_in_range) begin
                        o_ctl.nb_issue = 1'b1;
                        n_state        = S_N_CAP;
                    end else begin
                        go_nb_next = 1'b1;
                    end
                end
                S_N_CAP: begin
                    if (i_st.pt_valid) begin
                        o_ctl.nb_cap = 1'b1;
                        n_state      = S_MUL;
                    end else begin
                        go_nb_next = 1'b1;
                    end
                end
                S_MUL: begin
                    o_ctl.mul_step = 1'b1;
                    if (i_st.mul_last) begin
                        n_state = S_USE;
                    end
                end
                S_USE: begin
                    o_ctl.d_store = !r_ph2;
                    o_ctl.d_min   = r_ph2;
                    go_nb_next    = 1'b1;
                end
                S_MARK: begin
                    o_ctl.mark_wr  = 1'b1;
                    o_ctl.walk_inc = 1'b1;
                    if (i_st.walk_last) begin
                        n_pushcp = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_P_ISSUE;
                    end
                end
                S_SEL_INIT: begin
                    o_ctl.sel_init = 1'b1;
                    n_state        = S_SEL_RUN;
                end
                S_SEL_RUN: begin
                    o_ctl.sel_issue = 1'b1;
                    if (i_st.sel_last) begin
                        n_state = S_SEL_DRAIN;
                    end
                end
                S_SEL_DRAIN: begin
                    if (i_st.pipe_empty) begin
                        n_state = S_SEL_BIT;
                    end
                end
                S_SEL_BIT: begin
                    o_ctl.sel_bit = 1'b1;
                    if (!i_st.bit_last) begin
                        n_state = S_SEL_RUN;
                    end else if (!r_madm) begin
                        n_madm  = 1'b1;
                        n_state = S_SEL_INIT;
                    end else begin
                        n_state = S_THR_INIT;
                    end
                end
                S_THR_INIT: begin
                    o_ctl.thr_init = 1'b1;
                    n_state        = S_THR_MUL;
                end
                S_THR_MUL: begin
                    o_ctl.thr_mul = 1'b1;
                    n_state       = S_THR_ACC;
                end
                S_THR_ACC: begin
                    o_ctl.thr_acc = 1'b1;
                    if (i_st.thr_last) begin
                        n_fin   = 1'b1;
                        n_ph2   = 1'b1;
                        n_state = S_P_ISSUE;
                    end else begin
                        n_state = S_THR_MUL;
                    end
                end
                default: n_state = S_IDLE;
            endcase
        end

        if (go_nb_next) begin
            if (i_st.nb_last) begin
                go_cell_end = 1'b1;
            end else begin
                o_ctl.nb_inc = 1'b1;
                n_state      = S_N_ISSUE;
            end
        end

        if (go_cell_end) begin
            if (r_ph2) begin
                n_state = S_MARK;
            end else begin
                o_ctl.walk_inc = 1'b1;
                if (!i_st.walk_last) begin
                    n_state = S_P_ISSUE;
                end else if (i_st.n_zero) begin
                    o_ctl.zero_stats = 1'b1;
                    n_state          = S_THR_INIT;
                end else begin
                    n_madm  = 1'b0;
                    n_state = S_SEL_INIT;
                end
            end
        end
    end
endmodule

// File: rtl/gmor_dp.sv
`timescale 1ns / 1ps
// Datapath of the grid MAD outlier removal block: point, removed and distance
// memories, grid walk, distance unit, radix selection and threshold. Uses gmor_pkg.
module gmor_dp import gmor_pkg::*; #(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_ctl,
    output t_dp_status                   o_st,
    input  logic                         i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [ROWCOL_W-1:0]          i_row,
    input  logic [ROWCOL_W-1:0]          i_col,
    input  logic signed [FIELD_W-1:0]    i_x,
    input  logic signed [FIELD_W-1:0]    i_y,
    input  logic signed [FIELD_W-1:0]    i_z,
    input  logic                         i_valid_req,
    input  logic                         i_res_stall,
    output logic                         o_res_valid,
    output logic signed [FIELD_W-1:0]    o_out_x,
    output logic signed [FIELD_W-1:0]    o_out_y,
    output logic signed [FIELD_W-1:0]    o_out_z,
    output logic                         o_out_valid,
    output logic [CNT_W-1:0]             o_removed_total,
    output logic [D_W-1:0]               o_median_sq,
    output logic [D_W-1:0]               o_mad_sq,
    output logic [D_W-1:0]               o_threshold_sq
);
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int DAW   = $clog2(CELLS * 8);
    localparam int NW    = $clog2(CELLS * 8 + 1);
    localparam int RB    = $clog2(MAX_ROWS);
    localparam int CLB   = $clog2(MAX_COLS);
    localparam int CB    = COORD_BITS;
    localparam int PW    = 3 * CB + 1;
    localparam int SQ_W  = 2 * (CB + 1);
    localparam int EW    = GRID_IDX_W;

    // Configuration registers.
    logic [DIM_W-1:0]   r_rows, r_cols;
    logic [SIGMA_W-1:0] r_sigma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= ROWS_RST;
            r_cols  <= COLS_RST;
            r_sigma <= SIGMA_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROWS:  r_rows  <= i_cfg_data[DIM_W-1:0];
                CFG_COLS:  r_cols  <= i_cfg_data[DIM_W-1:0];
                CFG_SIGMA: r_sigma <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [EW-1:0] eff_rows, eff_cols;
    always_comb begin
        if (r_rows == '0) begin
            eff_rows = EW'(1);
        end else if (int'(r_rows) > MAX_ROWS) begin
            eff_rows = EW'(MAX_ROWS);
        end else begin
            eff_rows = EW'(r_rows);
        end
        if (r_cols == '0) begin
            eff_cols = EW'(1);
        end else if (int'(r_cols) > MAX_COLS) begin
            eff_cols = EW'(MAX_COLS);
        end else begin
            eff_cols = EW'(r_cols);
        end
    end

    // Grid walk and neighbor index.
    logic [RB-1:0]  r_wr;
    logic [CLB-1:0] r_wc;
    logic [2:0]     r_k;
    logic [AW-1:0]  walk_addr, nb_addr, in_addr;
    logic [EW-1:0]  nr, nc;
    logic           walk_last, in_inside;

    assign walk_last = (r_wr == RB'(MAX_ROWS - 1)) && (r_wc == CLB'(MAX_COLS - 1));
    assign walk_addr = AW'(int'(r_wr) * MAX_COLS + int'(r_wc));
    assign nr        = EW'(r_wr) + nb_dr(r_k);
    assign nc        = EW'(r_wc) + nb_dc(r_k);
    assign nb_addr   = AW'(int'(nr[RB-1:0]) * MAX_COLS + int'(nc[CLB-1:0]));
    assign in_inside = (int'(i_row) < MAX_ROWS) && (int'(i_col) < MAX_COLS);
    assign in_addr   = AW'(int'(i_row) * MAX_COLS + int'(i_col));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_wc <= '0;
        end else if (i_ctl.walk_rst) begin
            r_wr <= '0;
            r_wc <= '0;
        end else if (i_ctl.walk_inc) begin
            if (r_wc == CLB'(MAX_COLS - 1)) begin
                r_wc <= '0;
                r_wr <= (r_wr == RB'(MAX_ROWS - 1)) ? '0 : r_wr + RB'(1);
            end else begin
                r_wc <= r_wc + CLB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ctr_cap) begin
            r_k <= '0;
        end else if (i_ctl.nb_inc) begin
            r_k <= r_k + 3'd1;
        end
    end

    // Point memory: {valid, z, y, x}.
    logic          pt_we;
    logic [AW-1:0] pt_waddr, pt_raddr;
    logic [PW-1:0] pt_wdata, pt_rdata;

    always_comb begin
        pt_we    = 1'b0;
        pt_waddr = walk_addr;
        pt_wdata = '0;
        if (i_ctl.clr_wr) begin
            pt_we = 1'b1;
        end else if (i_ctl.ld_wr) begin
            pt_we    = in_inside;
            pt_waddr = in_addr;
            pt_wdata = {i_valid_req, i_z[CB-1:0], i_y[CB-1:0], i_x[CB-1:0]};
        end
        if (i_ctl.nb_issue) begin
            pt_raddr = nb_addr;
        end else if (i_ctl.pt_issue) begin
            pt_raddr = walk_addr;
        end else begin
            pt_raddr = in_addr;
        end
    end

    gmor_ram #(.WIDTH(PW), .DEPTH(CELLS)) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (pt_wdata),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    logic signed [CB-1:0] rd_x, rd_y, rd_z;
    logic                 rd_v;
    assign rd_x = pt_rdata[CB-1:0];
    assign rd_y = pt_rdata[2*CB-1:CB];
    assign rd_z = pt_rdata[3*CB-1:2*CB];
    assign rd_v = pt_rdata[3*CB];

    // Removed marks.
    logic          rm_we, rm_wdata, rm_rdata, mark;
    logic [AW-1:0] rm_waddr;

    always_comb begin
        rm_we    = 1'b0;
        rm_waddr = walk_addr;
        rm_wdata = 1'b0;
        if (i_ctl.clr_wr) begin
            rm_we = 1'b1;
        end else if (i_ctl.ld_wr) begin
            rm_we    = in_inside;
            rm_waddr = in_addr;
        end else if (i_ctl.mark_wr) begin
            rm_we    = 1'b1;
            rm_wdata = mark;
        end
    end

    gmor_ram #(.WIDTH(1), .DEPTH(CELLS)) u_rm_ram (
        .i_clk   (i_clk),
        .i_we    (rm_we),
        .i_waddr (rm_waddr),
        .i_wdata (rm_wdata),
        .i_raddr (in_addr),
        .o_rdata (rm_rdata)
    );

    // Read command capture.
    logic                 r_rd_ok, r_rd_v, r_rd_rem;
    logic signed [CB-1:0] r_rd_x, r_rd_y, r_rd_z;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_issue) begin
            r_rd_ok <= in_inside && (EW'(i_row) < eff_rows) && (EW'(i_col) < eff_cols);
        end
        if (i_ctl.rd_cap) begin
            r_rd_v   <= rd_v;
            r_rd_rem <= rm_rdata;
            r_rd_x   <= rd_x;
            r_rd_y   <= rd_y;
            r_rd_z   <= rd_z;
        end
    end

    // Distance unit: one shared squarer for the three axes.
    logic signed [CB-1:0] r_cx, r_cy, r_cz;
    logic signed [CB:0]   r_dx, r_dy, r_dz, sq_in;
    logic signed [SQ_W-1:0] r_sq;
    logic [D_W-1:0]       r_d;
    logic [1:0]           r_mj;
    logic                 r_ctr_ok, r_any;
    logic [D_W-1:0]       r_mn;

    always_comb begin
        case (r_mj)
            2'd0:    sq_in = r_dx;
            2'd1:    sq_in = r_dy;
            default: sq_in = r_dz;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ctr_cap) begin
            r_cx     <= rd_x;
            r_cy     <= rd_y;
            r_cz     <= rd_z;
            r_ctr_ok <= o_st.in_region && rd_v;
            r_any    <= 1'b0;
            r_mn     <= '1;
        end
        if (i_ctl.nb_cap) begin
            r_dx <= {r_cx[CB-1], r_cx} - {rd_x[CB-1], rd_x};
            r_dy <= {r_cy[CB-1], r_cy} - {rd_y[CB-1], rd_y};
            r_dz <= {r_cz[CB-1], r_cz} - {rd_z[CB-1], rd_z};
            r_mj <= '0;
            r_d  <= '0;
        end
        if (i_ctl.mul_step) begin
            if (r_mj != 2'd3) begin
                r_sq <= sq_in * sq_in;
            end
            if (r_mj != 2'd0) begin
                r_d <= r_d + D_W'($unsigned(r_sq));
            end
            r_mj <= r_mj + 2'd1;
        end
        if (i_ctl.d_min) begin
            r_any <= 1'b1;
            if (r_d < r_mn) begin
                r_mn <= r_d;
            end
        end
    end

    // Distance store and its fill count.
    logic [NW-1:0]  r_n;
    logic [DAW-1:0] r_i;
    logic [D_W-1:0] ds_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.n_rst) begin
            r_n <= '0;
        end else if (i_ctl.d_store && (r_d != '0)) begin
            r_n <= r_n + NW'(1);
        end
    end

    gmor_ram #(.WIDTH(D_W), .DEPTH(CELLS * 8)) u_ds_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.d_store && (r_d != '0)),
        .i_waddr (r_n[DAW-1:0]),
        .i_wdata (r_d),
        .i_raddr (r_i),
        .o_rdata (ds_rdata)
    );

    // Radix selection of element n/2, one bit per pass over the store.
    logic [D_W-1:0] r_res, r_hmask, r_bmask, r_v, r_med, r_mad, dev;
    logic [NW-1:0]  r_k_sel, r_cnt0;
    logic           r_va, r_vb, match0;

    assign dev    = (ds_rdata >= r_med) ? ds_rdata - r_med : r_med - ds_rdata;
    assign match0 = (((r_v ^ r_res) & r_hmask) == '0) && ((r_v & r_bmask) == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_ctl.sel_issue;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_va) begin
            r_v <= i_ctl.sel_mad ? dev : ds_rdata;
        end
        if (i_ctl.zero_stats) begin
            r_med <= '0;
            r_mad <= '0;
        end
        if (i_ctl.sel_init) begin
            r_res   <= '0;
            r_hmask <= '0;
            r_bmask <= {1'b1, {(D_W-1){1'b0}}};
            r_k_sel <= r_n >> 1;
            r_i     <= '0;
            r_cnt0  <= '0;
        end else if (i_ctl.sel_bit) begin
            if (r_k_sel >= r_cnt0) begin
                r_res   <= r_res | r_bmask;
                r_k_sel <= r_k_sel - r_cnt0;
            end
            if (r_bmask[0]) begin
                if (i_ctl.sel_mad) begin
                    r_mad <= (r_k_sel >= r_cnt0) ? (r_res | r_bmask) : r_res;
                end else begin
                    r_med <= (r_k_sel >= r_cnt0) ? (r_res | r_bmask) : r_res;
                end
            end
            r_hmask <= r_hmask | r_bmask;
            r_bmask <= r_bmask >> 1;
            r_i     <= '0;
            r_cnt0  <= '0;
        end else begin
            if (i_ctl.sel_issue) begin
                r_i <= r_i + DAW'(1);
            end
            if (r_vb && match0) begin
                r_cnt0 <= r_cnt0 + NW'(1);
            end
        end
    end

    // Threshold: median + floor(mad * k * 97162 / 2^24), one 13-bit digit per step.
    logic [KC_W-1:0]   r_kc;
    logic [D_W-1:0]    r_msh;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic [1:0]        r_tj;
    logic [TERM_W:0]   thr_sum;
    logic [D_W-1:0]    thr_sat;

    assign thr_sum = (TERM_W+1)'(r_med) + (TERM_W+1)'(r_acc[ACC_W-1:SCALE_SH]);
    assign thr_sat = (thr_sum[TERM_W:D_W] != '0) ? '1 : thr_sum[D_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.thr_init) begin
            r_kc  <= KC_W'(r_sigma) * MAD_INV_Q16;
            r_msh <= r_mad;
            r_acc <= '0;
            r_tj  <= '0;
        end
        if (i_ctl.thr_mul) begin
            r_prod <= PROD_W'(r_msh[D_W-1 -: DIGIT_W]) * PROD_W'(r_kc);
        end
        if (i_ctl.thr_acc) begin
            r_acc <= (r_acc << DIGIT_W) + ACC_W'(r_prod);
            r_msh <= r_msh << DIGIT_W;
            r_tj  <= r_tj + 2'd1;
        end
    end

    // Statistics and removed count.
    logic [D_W-1:0]   r_st_med, r_st_mad, r_st_thr;
    logic [CNT_W-1:0] r_rem_cnt;

    assign mark = r_ctr_ok && (!r_any || ((r_st_thr != '0) && (r_mn > r_st_thr)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_med  <= '0;
            r_st_mad  <= '0;
            r_st_thr  <= '0;
            r_rem_cnt <= '0;
        end else if (i_ctl.thr_fin) begin
            r_st_med  <= r_med;
            r_st_mad  <= r_mad;
            r_st_thr  <= thr_sat;
            r_rem_cnt <= '0;
        end else if (i_ctl.mark_wr && mark && (r_rem_cnt != REM_MAX)) begin
            r_rem_cnt <= r_rem_cnt + CNT_W'(1);
        end
    end

    // Output register.
    logic rd_show;
    assign rd_show = r_rd_ok && r_rd_v && !r_rd_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else if (i_ctl.push_rd || i_ctl.push_cp) begin
            o_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            o_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push_rd || i_ctl.push_cp) begin
            o_out_x         <= (i_ctl.push_rd && rd_show) ? FIELD_W'(r_rd_x) : '0;
            o_out_y         <= (i_ctl.push_rd && rd_show) ? FIELD_W'(r_rd_y) : '0;
            o_out_z         <= (i_ctl.push_rd && rd_show) ? FIELD_W'(r_rd_z) : '0;
            o_out_valid     <= i_ctl.push_rd && rd_show;
            o_removed_total <= r_rem_cnt;
            o_median_sq     <= r_st_med;
            o_mad_sq        <= r_st_mad;
            o_threshold_sq  <= r_st_thr;
        end
    end

    // Status back to the controller.
    always_comb begin
        o_st.walk_last   = walk_last;
        o_st.in_region   = (EW'(r_wr) < eff_rows) && (EW'(r_wc) < eff_cols);
        o_st.pt_valid    = rd_v;
        o_st.nb_last     = (r_k == 3'd7);
        o_st.nb_in_range = (nr < eff_rows) && (nc < eff_cols);
        o_st.mul_last    = (r_mj == 2'd3);
        o_st.n_zero      = (r_n == '0);
        o_st.sel_last    = ((NW'(r_i) + NW'(1)) == r_n);
        o_st.pipe_empty  = !r_va && !r_vb;
        o_st.bit_last    = r_bmask[0];
        o_st.thr_last    = (r_tj == 2'(DIGITS - 1));
        o_st.out_free    = !o_res_valid || !i_res_stall;
    end
endmodule

// File: tb/tb_grid_mad_outlier_removal_top.sv
`timescale 1ns / 1ps
// Testbench for grid_mad_outlier_removal_top: directed and random loads, computes and reads,
// checked against a behavioral predictor of the point grid and its MAD statistics.
// Depends on gmor_pkg and the block's RTL.
module tb_grid_mad_outlier_removal_top;
    import gmor_pkg::*;

    localparam int GRID_ROWS = 32;
    localparam int GRID_COLS = 32;
    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam logic [63:0] SAT52 = (64'd1 << 52) - 64'd1;
    localparam logic [63:0] INV_SCALE = 64'd97162;
    localparam int IDLE_LIMIT = 1000000;

    typedef struct packed {
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] z;
        logic               present;
        logic [CNT_W-1:0]   removed;
        logic [D_W-1:0]     median;
        logic [D_W-1:0]     mad;
        logic [D_W-1:0]     thresh;
    } t_point_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_req_valid = 1'b0;
    logic                      o_req_stall;
    logic [CMD_W-1:0]          i_cmd = CMD_NOP;
    logic [ROWCOL_W-1:0]       i_row = '0;
    logic [ROWCOL_W-1:0]       i_col = '0;
    logic signed [FIELD_W-1:0] i_x = '0;
    logic signed [FIELD_W-1:0] i_y = '0;
    logic signed [FIELD_W-1:0] i_z = '0;
    logic                      i_valid_req = 1'b0;
    logic                      o_res_valid;
    logic                      i_res_stall = 1'b0;
    logic signed [FIELD_W-1:0] o_out_x;
    logic signed [FIELD_W-1:0] o_out_y;
    logic signed [FIELD_W-1:0] o_out_z;
    logic                      o_out_valid;
    logic [CNT_W-1:0]          o_removed_total;
    logic [D_W-1:0]            o_median_sq;
    logic [D_W-1:0]            o_mad_sq;
    logic [D_W-1:0]            o_threshold_sq;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    grid_mad_outlier_removal_top i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state.
    logic signed [FIELD_W-1:0] grid_x [CELLS];
    logic signed [FIELD_W-1:0] grid_y [CELLS];
    logic signed [FIELD_W-1:0] grid_z [CELLS];
    bit                        grid_present [CELLS];
    bit                        grid_removed [CELLS];
    logic [D_W-1:0]            stat_median = '0;
    logic [D_W-1:0]            stat_mad = '0;
    logic [D_W-1:0]            stat_thresh = '0;
    logic [CNT_W-1:0]          cull_tally = '0;
    logic [DIM_W-1:0]          rows_reg = ROWS_RST;
    logic [DIM_W-1:0]          cols_reg = COLS_RST;
    logic [SIGMA_W-1:0]        sigma_reg = SIGMA_RST;

    t_point_result pending_results[$];
    int mismatches = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int top);
        if (v < 1) return 1;
        return (v > top) ? top : int'(v);
    endfunction

    function automatic logic [63:0] dist_sq(input int p, input int q);
        longint dx, dy, dz;
        dx = longint'(grid_x[p]) - longint'(grid_x[q]);
        dy = longint'(grid_y[p]) - longint'(grid_y[q]);
        dz = longint'(grid_z[p]) - longint'(grid_z[q]);
        return 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
    endfunction

    // Neighbor statistics followed by the removal marks.
    function automatic void find_outliers();
        logic [63:0] dists[$];
        logic [63:0] med, mad, kc, term, thr, d, nearest;
        int nrows, ncols, p, q, nr, nc, cnt;
        nrows = clamp_dim(rows_reg, GRID_ROWS);
        ncols = clamp_dim(cols_reg, GRID_COLS);
        for (int r = 0; r < nrows; r++) begin
            for (int c = 0; c < ncols; c++) begin
                p = r * GRID_COLS + c;
                if (!grid_present[p]) continue;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        nr = r + dr;
                        nc = c + dc;
                        if ((dr == 0 && dc == 0) || nr < 0 || nc < 0 || nr >= nrows || nc >= ncols)
                            continue;
                        q = nr * GRID_COLS + nc;
                        if (!grid_present[q]) continue;
                        d = dist_sq(p, q);
                        if (d != 0) dists.insert(dists.size(), d);
                    end
                end
            end
        end
        med = 0;
        mad = 0;
        if (dists.size() > 0) begin
            dists.sort();
            med = dists[dists.size() / 2];
            foreach (dists[i]) dists[i] = (dists[i] >= med) ? dists[i] - med : med - dists[i];
            dists.sort();
            mad = dists[dists.size() / 2];
        end
        kc = 64'(sigma_reg) * INV_SCALE;
        term = (mad >> 24) * kc + (((mad & 64'hFF_FFFF) * kc) >> 24);
        thr = med + term;
        if (thr > SAT52) thr = SAT52;
        stat_median = med[D_W-1:0];
        stat_mad = mad[D_W-1:0];
        stat_thresh = thr[D_W-1:0];

        cull_tally = '0;
        for (int i = 0; i < CELLS; i++) grid_removed[i] = 1'b0;
        for (int r = 0; r < nrows; r++) begin
            for (int c = 0; c < ncols; c++) begin
                p = r * GRID_COLS + c;
                if (!grid_present[p]) continue;
                cnt = 0;
                nearest = '1;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        nr = r + dr;
                        nc = c + dc;
                        if ((dr == 0 && dc == 0) || nr < 0 || nc < 0 || nr >= nrows || nc >= ncols)
                            continue;
                        q = nr * GRID_COLS + nc;
                        if (!grid_present[q]) continue;
                        d = dist_sq(p, q);
                        if (d < nearest) nearest = d;
                        cnt++;
                    end
                end
                if (cnt == 0 || (thr > 0 && nearest > thr)) begin
                    grid_removed[p] = 1'b1;
                    if (cull_tally < REM_MAX) cull_tally++;
                end
            end
        end
    endfunction

    function automatic void apply_command(input t_cmd cmd, input int row, input int col,
                                          input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                                          input logic [FIELD_W-1:0] z, input bit present);
        t_point_result res;
        int p;
        p = row * GRID_COLS + col;
        case (cmd)
            CMD_LOAD: begin
                grid_x[p] = x;
                grid_y[p] = y;
                grid_z[p] = z;
                grid_present[p] = present;
                grid_removed[p] = 1'b0;
            end
            CMD_COMPUTE, CMD_READ: begin
                if (cmd == CMD_COMPUTE) find_outliers();
                res = '0;
                if (cmd == CMD_READ && row < clamp_dim(rows_reg, GRID_ROWS)
                    && col < clamp_dim(cols_reg, GRID_COLS) && grid_present[p] && !grid_removed[p]) begin
                    res.x = grid_x[p];
                    res.y = grid_y[p];
                    res.z = grid_z[p];
                    res.present = 1'b1;
                end
                res.removed = cull_tally;
                res.median = stat_median;
                res.mad = stat_mad;
                res.thresh = stat_thresh;
                pending_results.insert(pending_results.size(), res);
            end
            default: ;
        endcase
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_point_result got, want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            got = '{o_out_x, o_out_y, o_out_z, o_out_valid, o_removed_total,
                    o_median_sq, o_mad_sq, o_threshold_sq};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transaction: %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at %0t:\n  expected %p\n  actual   %p", $time, want, got);
                end
            end
        end
    end

    always @(posedge i_clk) i_res_stall <= ($urandom_range(99) < stall_pct);

    // Watchdog on cycles with no transaction on any channel.
    always @(posedge i_clk) begin
        if ((i_req_valid && !o_req_stall) || (o_res_valid && !i_res_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input t_cmd cmd, input int row, input int col,
                             input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                             input logic [FIELD_W-1:0] z, input bit present);
        while ($urandom_range(99) < idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_cmd <= cmd;
        i_row <= ROWCOL_W'(row);
        i_col <= ROWCOL_W'(col);
        i_x <= x;
        i_y <= y;
        i_z <= z;
        i_valid_req <= present;
        do @(posedge i_clk); while (o_req_stall);
        apply_command(cmd, row, col, x, y, z, present);
    endtask

    // Lets the block go idle; loads give no result, so the wait goes on past the last result.
    task automatic wait_idle();
        i_req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ROWS:  rows_reg = data[DIM_W-1:0];
            CFG_COLS:  cols_reg = data[DIM_W-1:0];
            CFG_SIGMA: sigma_reg = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_region(input int rows, input int cols, input int sigma);
        wait_idle();
        write_reg(CFG_ROWS, {(CFG_DATA_W-DIM_W)'($urandom_range(1023)), DIM_W'(rows)});
        write_reg(CFG_COLS, {(CFG_DATA_W-DIM_W)'($urandom_range(1023)), DIM_W'(cols)});
        write_reg(CFG_SIGMA, CFG_DATA_W'(sigma));
    endtask

    task automatic test_directed();
        send_item(CMD_READ, 0, 0, '0, '0, '0, 1'b0);
        send_item(CMD_COMPUTE, 0, 0, '0, '0, '0, 1'b0);
        send_item(CMD_LOAD, 31, 31, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 1'b1);
        send_item(CMD_LOAD, 31, 30, 24'h80_0000, 24'h80_0000, 24'h80_0000, 1'b1);
        send_item(CMD_LOAD, 30, 31, '0, '0, '0, 1'b1);
        send_item(CMD_LOAD, 0, 0, 24'h00_0100, 24'hFF_FF00, 24'h00_0001, 1'b1);
        send_item(CMD_LOAD, 5, 5, '1, '1, '1, 1'b0);
        send_item(CMD_NOP, 31, 31, '1, '1, '1, 1'b1);
        send_item(CMD_COMPUTE, 0, 0, '0, '0, '0, 1'b0);
        send_item(CMD_READ, 31, 31, '0, '0, '0, 1'b0);
        send_item(CMD_READ, 31, 30, '0, '0, '0, 1'b0);
        send_item(CMD_READ, 30, 31, '0, '0, '0, 1'b0);
        send_item(CMD_READ, 0, 0, '0, '0, '0, 1'b0);
        send_item(CMD_READ, 5, 5, '0, '0, '0, 1'b0);
        // A twin point gives a zero distance, so (0,0) is no longer isolated.
        send_item(CMD_LOAD, 0, 1, 24'h00_0100, 24'hFF_FF00, 24'h00_0001, 1'b1);
        send_item(CMD_READ, 0, 0, '0, '0, '0, 1'b0);
        send_item(CMD_COMPUTE, 0, 0, '0, '0, '0, 1'b0);
        send_item(CMD_READ, 0, 0, '0, '0, '0, 1'b0);
        send_item(CMD_READ, 0, 1, '0, '0, '0, 1'b0);
        // Reloading a removed cell clears its mark.
        send_item(CMD_LOAD, 31, 31, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 1'b1);
        send_item(CMD_READ, 31, 31, '0, '0, '0, 1'b0);
    endtask

    task automatic test_config();
        // Zero acts as one row; an oversized column count saturates.
        set_region(0, 63, 0);
        send_item(CMD_COMPUTE, 0, 0, '0, '0, '0, 1'b0);
        send_item(CMD_READ, 0, 0, '0, '0, '0, 1'b0);
        send_item(CMD_READ, 0, 31, '0, '0, '0, 1'b0);
        // Only the twin points are in use: no nonzero distance at all.
        set_region(2, 2, 65535);
        send_item(CMD_COMPUTE, 0, 0, '0, '0, '0, 1'b0);
        send_item(CMD_READ, 0, 1, '0, '0, '0, 1'b0);
        send_item(CMD_READ, 2, 0, '0, '0, '0, 1'b0);
        set_region(1, 1, 65535);
        send_item(CMD_COMPUTE, 0, 0, '0, '0, '0, 1'b0);
        send_item(CMD_READ, 0, 0, '0, '0, '0, 1'b0);
        set_region(32, 32, 65535);
        send_item(CMD_COMPUTE, 0, 0, '0, '0, '0, 1'b0);
        send_item(CMD_READ, 31, 30, '0, '0, '0, 1'b0);
    endtask

    // Mostly a jittered lattice in the low corner of the grid with some far outliers.
    task automatic test_random(input int count, input int idle, input int stall,
                               input int rows, input int cols, input int sigma);
        int row, col, pick;
        logic [FIELD_W-1:0] x, y, z;
        bit present;
        set_region(rows, cols, sigma);
        idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            row = $urandom_range(7);
            col = $urandom_range(7);
            if (pick < 60) begin
                x = FIELD_W'(col * 1024 + $urandom_range(511) - 256);
                y = FIELD_W'(row * 1024 + $urandom_range(511) - 256);
                z = FIELD_W'($urandom_range(511) - 256);
                if ($urandom_range(9) == 0) begin
                    x = FIELD_W'($urandom);
                    y = FIELD_W'($urandom);
                    z = FIELD_W'($urandom);
                end
                present = ($urandom_range(99) < 85);
                // Cells outside the low corner are written as absent to bound compute time.
                if ($urandom_range(19) == 0) begin
                    row = $urandom_range(31);
                    col = $urandom_range(31);
                    present = (row < 8 && col < 8) ? present : 1'b0;
                end
                send_item(CMD_LOAD, row, col, x, y, z, present);
            end else if (pick < 95) begin
                if ($urandom_range(9) == 0) begin
                    row = $urandom_range(31);
                    col = $urandom_range(31);
                end
                send_item(CMD_READ, row, col, '0, '0, '0, 1'b0);
            end else if (pick < 97) begin
                send_item(CMD_NOP, $urandom_range(31), $urandom_range(31), FIELD_W'($urandom),
                          FIELD_W'($urandom), FIELD_W'($urandom), 1'($urandom));
            end else begin
                send_item(CMD_COMPUTE, row, col, '0, '0, '0, 1'b0);
                if ($urandom_range(3) == 0) wait_idle();
            end
        end
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < CELLS; i++) begin
            grid_x[i] = '0;
            grid_y[i] = '0;
            grid_z[i] = '0;
            grid_present[i] = 1'b0;
            grid_removed[i] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config();
        test_random(350, 0, 0, $urandom_range(3, 8), $urandom_range(3, 8), $urandom_range(65535));
        test_random(350, 83, 0, $urandom_range(3, 8), $urandom_range(3, 8), 0);
        test_random(350, 0, 83, 32, 32, $urandom_range(256, 1024));
        test_random(350, 16, 16, $urandom_range(3, 8), $urandom_range(3, 8), 65535);
        stall_pct = 0;
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/gmor_pkg.sv
rtl/gmor_ram.sv
rtl/gmor_ctrl.sv
rtl/gmor_dp.sv
rtl/grid_mad_outlier_removal_top.sv
tb/tb_grid_mad_outlier_removal_top.sv
